// ===== rtl/iterated_five_point_smoother_assert.svh =====
// Assertion macros of the smoother RTL, used by i5s_back.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ITERATED_FIVE_POINT_SMOOTHER_ASSERT_SVH
`define ITERATED_FIVE_POINT_SMOOTHER_ASSERT_SVH

// Same-cycle implication.
`define I5S_ASSERT_NOW(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("i5s check failed");

// Next-cycle implication.
`define I5S_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("i5s check failed");

`endif

// ===== rtl/i5s_pkg.sv =====
// Shared types, codes and helpers of the five-point smoother.
// No dependencies.
package i5s_pkg;

	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS_DEF    = 256;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_SMOOTH = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	localparam logic [2:0] CFG_COLUMNS  = 3'd0;
	localparam logic [2:0] CFG_ROWS     = 3'd1;
	localparam logic [2:0] CFG_PASSES   = 3'd2;
	localparam logic [2:0] CFG_CENTER   = 3'd3;
	localparam logic [2:0] CFG_NEIGHBOR = 3'd4;
	localparam logic [2:0] CFG_GAIN     = 3'd5;

	typedef struct packed {
		logic [1:0]         op;
		logic [15:0]        idx;
		logic signed [31:0] sample;
	} item_t;

	typedef struct packed {
		logic [8:0]  columns;
		logic [8:0]  rows;
		logic [5:0]  passes;
		logic [15:0] center;
		logic [15:0] neighbor;
		logic [23:0] gain;
	} cfg_t;

	// Floor away 16 fraction bits, then clip to the signed 32-bit range.
	function automatic logic signed [31:0] sat_q16(input logic signed [63:0] v);
		logic signed [47:0] s;
		s = 48'(v >>> 16);
		if (s > 48'sh0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (s < -48'sh0000_8000_0000)
			return -32'sh8000_0000;
		return 32'(s);
	endfunction

endpackage

// ===== rtl/i5s_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i5s_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/i5s_front.sv =====
// Front end: accepts input beats into a two-entry queue for the engine.
// Depends on i5s_pkg.
module i5s_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [47:0]     s_axis_tdata,  // point_index[15:0], sample_value[47:16]
	input  logic [1:0]      s_axis_tuser,  // opcode
	output logic            item_valid,
	output i5s_pkg::item_t  item,
	input  logic            pop
);

	i5s_pkg::item_t slot_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     count_q;
	logic           push;

	assign s_axis_tready = (count_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign item_valid    = (count_q != 2'd0);
	assign item          = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q].op     <= s_axis_tuser;
			slot_q[wp_q].idx    <= s_axis_tdata[15:0];
			slot_q[wp_q].sample <= s_axis_tdata[47:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/i5s_back.sv =====
// Back end: executes writes, reads and the smoothing sequence over the stores.
// Depends on i5s_pkg, i5s_ram and the assertion macro header.
`include "iterated_five_point_smoother_assert.svh"

module i5s_back #(
	parameter int MAX_COLUMNS = i5s_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = i5s_pkg::MAX_ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  i5s_pkg::cfg_t       cfg,
	input  logic                item_valid,
	input  i5s_pkg::item_t      item,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic signed [31:0]  m_value,
	output logic                m_flag
);

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CWID  = $clog2(MAX_COLUMNS + 1);
	localparam int RWID  = $clog2(MAX_ROWS + 1);
	localparam int DW0   = (CWID > RWID) ? CWID : RWID;
	localparam int DIMW  = (DW0 > 9) ? DW0 : 9;
	localparam int NW    = 2 * DIMW;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RDW  = 4'd1;
	localparam logic [3:0] ST_CRD  = 4'd2;
	localparam logic [3:0] ST_CWR  = 4'd3;
	localparam logic [3:0] ST_PT   = 4'd4;
	localparam logic [3:0] ST_BWR  = 4'd5;
	localparam logic [3:0] ST_STEN = 4'd6;
	localparam logic [3:0] ST_MUL  = 4'd7;
	localparam logic [3:0] ST_ACC  = 4'd8;
	localparam logic [3:0] ST_GRD  = 4'd9;
	localparam logic [3:0] ST_GMUL = 4'd10;
	localparam logic [3:0] ST_GWR  = 4'd11;

	logic [3:0]         state_q;
	logic [AW-1:0]      k_q;
	logic [DIMW-1:0]    r_q, c_q;
	logic [2:0]         j_q;
	logic [5:0]         pass_q;
	logic               sel_q, flag_q, rd_ok_q;
	logic               out_valid_q, out_flag_q;
	logic signed [31:0] out_value_q, center_q;
	logic signed [34:0] nsum_q;
	logic signed [48:0] pc_q;
	logic signed [50:0] pn_q;
	logic signed [56:0] pg_q;

	logic [DIMW-1:0]    cols_c, rows_c;
	logic [NW-1:0]      n_c;
	logic               last_k, border, free, idx_ok;
	logic [AW-1:0]      sten_addr;

	logic               s_we;
	logic [AW-1:0]      s_waddr, s_raddr, w_waddr, w_raddr;
	logic [31:0]        s_wdata, s_rdata, w_wdata;
	logic [1:0]         w_we;
	logic [31:0]        w_rdata [2];
	logic signed [31:0] src_data;

	always_comb begin
		if (cfg.columns < 9'd3)
			cols_c = DIMW'(3);
		else if (DIMW'(cfg.columns) > DIMW'(MAX_COLUMNS))
			cols_c = DIMW'(MAX_COLUMNS);
		else
			cols_c = DIMW'(cfg.columns);
		if (cfg.rows < 9'd3)
			rows_c = DIMW'(3);
		else if (DIMW'(cfg.rows) > DIMW'(MAX_ROWS))
			rows_c = DIMW'(MAX_ROWS);
		else
			rows_c = DIMW'(cfg.rows);
	end

	assign n_c      = NW'(cols_c) * NW'(rows_c);
	assign last_k   = (NW'(k_q) == n_c - NW'(1));
	assign border   = (r_q == '0) || (r_q == rows_c - DIMW'(1)) ||
	                  (c_q == '0) || (c_q == cols_c - DIMW'(1));
	assign free     = !out_valid_q || m_tready;
	assign idx_ok   = (32'(item.idx) < 32'(DEPTH));
	assign src_data = w_rdata[sel_q];

	always_comb begin
		case (j_q)
			3'd1:    sten_addr = k_q - AW'(cols_c);
			3'd2:    sten_addr = k_q + AW'(cols_c);
			3'd3:    sten_addr = k_q - AW'(1);
			3'd4:    sten_addr = k_q + AW'(1);
			default: sten_addr = k_q;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		s_we    = 1'b0;
		s_waddr = AW'(item.idx);
		s_wdata = item.sample;
		s_raddr = k_q;
		w_we    = 2'b00;
		w_waddr = k_q;
		w_wdata = '0;
		w_raddr = k_q;
		case (state_q)
			ST_IDLE: begin
				pop = item_valid && free;
				if (pop && item.op == i5s_pkg::OP_WRITE && idx_ok)
					s_we = 1'b1;
				w_raddr = AW'(item.idx);
			end
			ST_CWR: begin
				w_we[0] = 1'b1;
				w_wdata = s_rdata;
			end
			ST_BWR: begin
				w_we[!sel_q] = 1'b1;
				w_wdata      = src_data;
			end
			ST_STEN: w_raddr = sten_addr;
			ST_ACC: begin
				w_we[!sel_q] = 1'b1;
				w_wdata      = i5s_pkg::sat_q16(64'(pc_q) + 64'(pn_q));
			end
			ST_GWR: begin
				w_we[sel_q] = 1'b1;
				w_wdata     = i5s_pkg::sat_q16(64'(pg_q));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_RDW: out_value_q <= rd_ok_q ? src_data : 32'sd0;
			ST_STEN: begin
				if (j_q == 3'd0)
					nsum_q <= '0;
				else if (j_q == 3'd1)
					center_q <= src_data;
				else
					nsum_q <= nsum_q + 35'(src_data);
			end
			ST_MUL: begin
				pc_q <= $signed({1'b0, cfg.center}) * center_q;
				pn_q <= $signed({1'b0, cfg.neighbor}) * nsum_q;
			end
			ST_GMUL: pg_q <= $signed({1'b0, cfg.gain}) * src_data;
			// A waiting read beat must keep its value, so clear only on a new item or in the gain writes.
			default: if ((state_q == ST_IDLE && pop) || state_q == ST_GWR)
				out_value_q <= '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			r_q         <= '0;
			c_q         <= '0;
			j_q         <= '0;
			pass_q      <= '0;
			sel_q       <= 1'b0;
			flag_q      <= 1'b0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_flag_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (item.op)
							i5s_pkg::OP_WRITE: begin
								flag_q      <= 1'b0;
								out_valid_q <= 1'b1;
								out_flag_q  <= 1'b0;
							end
							i5s_pkg::OP_SMOOTH: begin
								k_q     <= '0;
								state_q <= ST_CRD;
							end
							i5s_pkg::OP_READ: begin
								rd_ok_q <= (32'(item.idx) < 32'(n_c));
								state_q <= ST_RDW;
							end
							default: begin
								out_valid_q <= 1'b1;
								out_flag_q  <= flag_q;
							end
						endcase
					end
				end
				ST_RDW: begin
					out_valid_q <= 1'b1;
					out_flag_q  <= flag_q;
					state_q     <= ST_IDLE;
				end
				ST_CRD: state_q <= ST_CWR;
				ST_CWR: begin
					if (last_k) begin
						k_q     <= '0;
						r_q     <= '0;
						c_q     <= '0;
						pass_q  <= '0;
						sel_q   <= 1'b0;
						state_q <= (cfg.passes == 6'd0) ? ST_GRD : ST_PT;
					end else begin
						k_q     <= k_q + AW'(1);
						state_q <= ST_CRD;
					end
				end
				ST_PT: begin
					j_q     <= '0;
					state_q <= border ? ST_BWR : ST_STEN;
				end
				ST_STEN: begin
					j_q <= j_q + 3'd1;
					if (j_q == 3'd5)
						state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ACC;
				ST_BWR, ST_ACC: begin
					if (last_k) begin
						k_q   <= '0;
						r_q   <= '0;
						c_q   <= '0;
						sel_q <= !sel_q;
						if (6'(pass_q + 6'd1) == cfg.passes) begin
							state_q <= ST_GRD;
						end else begin
							pass_q  <= pass_q + 6'd1;
							state_q <= ST_PT;
						end
					end else begin
						k_q <= k_q + AW'(1);
						if (c_q == cols_c - DIMW'(1)) begin
							c_q <= '0;
							r_q <= r_q + DIMW'(1);
						end else begin
							c_q <= c_q + DIMW'(1);
						end
						state_q <= ST_PT;
					end
				end
				ST_GRD: state_q <= ST_GMUL;
				ST_GMUL: state_q <= ST_GWR;
				ST_GWR: begin
					if (last_k) begin
						flag_q      <= 1'b1;
						out_valid_q <= 1'b1;
						out_flag_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						k_q     <= k_q + AW'(1);
						state_q <= ST_GRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_value  = out_value_q;
	assign m_flag   = out_flag_q;

	i5s_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_sample (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	i5s_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_work0 (
		.clk(clk), .we(w_we[0]), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata[0])
	);

	i5s_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_work1 (
		.clk(clk), .we(w_we[1]), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata[1])
	);

	`I5S_ASSERT_NOW(a_pop_idle, pop, state_q == ST_IDLE)
	`I5S_ASSERT_NOW(a_one_bank, 1'b1, !(w_we[0] && w_we[1]))
	`I5S_ASSERT_NOW(a_sten_step, state_q == ST_STEN, j_q <= 3'd5)
	`I5S_ASSERT_NEXT(a_done_flag, state_q == ST_GWR && last_k, flag_q && out_valid_q)

endmodule

// ===== rtl/iterated_five_point_smoother.sv =====
// Top level of the iterated five-point smoother. A write or unused opcode is
// queued, taken and its result beat registered; a read adds a read-wait state.
// Writes and unused opcodes sustain one beat per cycle while the receiver is
// ready. A smooth copies the N grid points, runs the passes, applies the gain;
// the work stores have a single read port, so stencil points are read in turn.
// Reset clears control state and the smoothed flag; the stores stay unset.
module iterated_five_point_smoother #(
	parameter int MAX_COLUMNS = i5s_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = i5s_pkg::MAX_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // point_index[15:0], sample_value[47:16]
	input  logic [1:0]  s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // result_value[31:0]
	output logic        m_axis_tuser,  // result_valid
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	i5s_pkg::cfg_t      cfg_q;
	i5s_pkg::item_t     item;
	logic               item_valid, pop;
	logic signed [31:0] value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.columns  <= 9'd182;
			cfg_q.rows     <= 9'd149;
			cfg_q.passes   <= 6'd20;
			cfg_q.center   <= 16'd32768;
			cfg_q.neighbor <= 16'd8192;
			cfg_q.gain     <= 24'd2055786;
		end else if (cfg_we) begin
			case (cfg_index)
				i5s_pkg::CFG_COLUMNS:  cfg_q.columns  <= cfg_data[8:0];
				i5s_pkg::CFG_ROWS:     cfg_q.rows     <= cfg_data[8:0];
				i5s_pkg::CFG_PASSES:   cfg_q.passes   <= cfg_data[5:0];
				i5s_pkg::CFG_CENTER:   cfg_q.center   <= cfg_data[15:0];
				i5s_pkg::CFG_NEIGHBOR: cfg_q.neighbor <= cfg_data[15:0];
				i5s_pkg::CFG_GAIN:     cfg_q.gain     <= cfg_data;
				default: ;
			endcase
		end
	end

	i5s_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.item_valid(item_valid), .item(item), .pop(pop)
	);

	i5s_back #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.item_valid(item_valid), .item(item), .pop(pop),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
		.m_value(value), .m_flag(m_axis_tuser)
	);

	assign m_axis_tdata = value;

endmodule

// ===== verif/tb_iterated_five_point_smoother.sv =====
// Self-checking testbench for iterated_five_point_smoother: stream stimulus, a
// behavioral model of the stencil smoother and a result checker.
// Depends on i5s_pkg and the RTL top level only.
module tb_iterated_five_point_smoother;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = i5s_pkg::MAX_COLUMNS_DEF * i5s_pkg::MAX_ROWS_DEF;
	localparam int IDLE_LIMIT  = 1500000;
	localparam int RANDOM_ITEMS = 700;

	typedef struct {
		logic [31:0] value;
		logic        done;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = i5s_pkg::OP_WRITE;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = i5s_pkg::CFG_COLUMNS;
	logic [23:0] cfg_data = '0;

	iterated_five_point_smoother u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Model state of the smoother.
	logic signed [31:0] sample_mem [STORE_DEPTH];
	logic signed [31:0] smooth_mem [STORE_DEPTH];
	logic signed [31:0] next_mem [STORE_DEPTH];
	bit                 smooth_set [STORE_DEPTH];
	bit                 grid_done;
	logic [8:0]  m_cols = 9'd182, m_rows = 9'd149;
	logic [5:0]  m_passes = 6'd20;
	logic [15:0] m_center = 16'd32768, m_neighbor = 16'd8192;
	logic [23:0] m_gain = 24'd2055786;

	beat_t pending_results[$];
	int    mismatches = 0;
	int    items_sent = 0;
	int    smooths_run = 0;
	int    reads_run = 0;
	int    burst_left = 0;
	bit    sender_gaps = 1'b0;
	bit    receiver_stalls = 1'b0;
	int    stall_asked = 0;
	int    stall_served = 0;
	int    stall_left = 0;
	int    idle_cycles = 0;

	function automatic int grid_dim(input logic [8:0] v);
		if (v < 3) return 3;
		if (v > 256) return 256;
		return int'(v);
	endfunction

	function automatic int grid_points();
		return grid_dim(m_cols) * grid_dim(m_rows);
	endfunction

	// Keep the integer part of a Q.16 product (floor) and clip to 32 bits.
	function automatic logic signed [31:0] floor_clip(input longint v);
		longint q;
		q = v >>> 16;
		if (q > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (q < -64'sd2147483648) return 32'sh8000_0000;
		return q[31:0];
	endfunction

	task automatic run_stencil();
		int     cols, rows, n, k;
		longint nsum, acc;
		cols = grid_dim(m_cols);
		rows = grid_dim(m_rows);
		n = cols * rows;
		for (int i = 0; i < n; i++) begin
			smooth_mem[i] = sample_mem[i];
			next_mem[i] = sample_mem[i];
			smooth_set[i] = 1'b1;
		end
		for (int p = 0; p < m_passes; p++) begin
			for (int r = 1; r < rows - 1; r++)
				for (int c = 1; c < cols - 1; c++) begin
					k = r * cols + c;
					nsum = longint'(smooth_mem[k - cols]) + longint'(smooth_mem[k + cols])
						+ longint'(smooth_mem[k - 1]) + longint'(smooth_mem[k + 1]);
					acc = longint'(m_center) * longint'(smooth_mem[k])
						+ longint'(m_neighbor) * nsum;
					next_mem[k] = floor_clip(acc);
				end
			for (int i = 0; i < n; i++)
				smooth_mem[i] = next_mem[i];
		end
		for (int i = 0; i < n; i++)
			smooth_mem[i] = floor_clip(longint'(m_gain) * longint'(smooth_mem[i]));
	endtask

	task automatic predict_beat(input logic [1:0] op, input logic [15:0] idx,
			input logic [31:0] sample);
		beat_t b;
		b.value = '0;
		case (op)
			i5s_pkg::OP_WRITE: begin
				sample_mem[idx] = sample;
				grid_done = 1'b0;
			end
			i5s_pkg::OP_SMOOTH: begin
				run_stencil();
				grid_done = 1'b1;
				smooths_run++;
			end
			i5s_pkg::OP_READ: begin
				if (int'(idx) < grid_points())
					b.value = smooth_mem[idx];
				reads_run++;
			end
			default: ;
		endcase
		b.done = grid_done;
		pending_results.push_back(b);
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
	endtask

	// Sends one beat; gaps between bursts are inserted when enabled.
	task automatic send_item(input logic [1:0] op, input logic [15:0] idx,
			input logic [31:0] sample);
		if (sender_gaps && burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {sample, idx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (burst_left > 0) burst_left--;
		items_sent++;
		predict_beat(op, idx, sample);
	endtask

	// Stops offering and waits until every expected beat has been checked.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_reg(input logic [2:0] index, input logic [23:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		case (index)
			i5s_pkg::CFG_COLUMNS:  m_cols = value[8:0];
			i5s_pkg::CFG_ROWS:     m_rows = value[8:0];
			i5s_pkg::CFG_PASSES:   m_passes = value[5:0];
			i5s_pkg::CFG_CENTER:   m_center = value[15:0];
			i5s_pkg::CFG_NEIGHBOR: m_neighbor = value[15:0];
			i5s_pkg::CFG_GAIN:     m_gain = value;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [8:0] cols, input logic [8:0] rows,
			input logic [5:0] passes, input logic [15:0] center,
			input logic [15:0] neighbor, input logic [23:0] gain);
		set_reg(i5s_pkg::CFG_COLUMNS, 24'(cols));
		set_reg(i5s_pkg::CFG_ROWS, 24'(rows));
		set_reg(i5s_pkg::CFG_PASSES, 24'(passes));
		set_reg(i5s_pkg::CFG_CENTER, 24'(center));
		set_reg(i5s_pkg::CFG_NEIGHBOR, 24'(neighbor));
		set_reg(i5s_pkg::CFG_GAIN, gain);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 1) ? 32'(-$urandom_range(0, 300000))
				: 32'($urandom_range(0, 300000));
			default: return $urandom;
		endcase
	endfunction

	task automatic fill_grid();
		for (int i = 0; i < grid_points(); i++)
			send_item(i5s_pkg::OP_WRITE, 16'(i), pick_sample());
	endtask

	// Reads an index inside the grid only if a smooth has produced it.
	task automatic read_point(input int idx);
		if (idx < grid_points() && !smooth_set[idx])
			idx = grid_points();
		send_item(i5s_pkg::OP_READ, 16'(idx), $urandom);
	endtask

	task automatic test_directed();
		configure(9'd3, 9'd3, 6'd1, 16'd32768, 16'd8192, 24'h010000);
		send_item(i5s_pkg::OP_READ, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(i5s_pkg::OP_WRITE, 16'd0, 32'h7FFF_FFFF);
		send_item(i5s_pkg::OP_WRITE, 16'd1, 32'h8000_0000);
		send_item(i5s_pkg::OP_WRITE, 16'd2, 32'h0000_0000);
		for (int i = 3; i < 9; i++)
			send_item(i5s_pkg::OP_WRITE, 16'(i), pick_sample());
		send_item(i5s_pkg::OP_NOP, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(i5s_pkg::OP_SMOOTH, 16'd0, 32'd0);
		for (int i = 0; i < 9; i++)
			read_point(i);
		send_item(i5s_pkg::OP_READ, 16'd9, 32'd0);
		send_item(i5s_pkg::OP_WRITE, 16'd4, 32'h0001_0000);
		read_point(4);
		drain();
	endtask

	// Columns below range and rows above it clamp to a 3 x 256 grid; no passes.
	task automatic test_clamp_zero_passes();
		configure(9'd0, 9'd511, 6'd0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		fill_grid();
		send_item(i5s_pkg::OP_SMOOTH, 16'd0, 32'd0);
		for (int i = 0; i < 20; i++)
			read_point($urandom_range(0, 800));
		drain();
	endtask

	// Widest grid, most passes, largest weights; zero gain, then the largest gain.
	task automatic test_wide_grid_max_passes();
		configure(9'd256, 9'd3, 6'd63, 16'hFFFF, 16'hFFFF, 24'h000000);
		for (int i = 0; i < 30; i++)
			send_item(i5s_pkg::OP_WRITE, 16'($urandom_range(0, 767)), pick_sample());
		send_item(i5s_pkg::OP_SMOOTH, 16'd0, 32'd0);
		read_point(0);
		drain();
		set_reg(i5s_pkg::CFG_GAIN, 24'hFFFFFF);
		cfg_we <= 1'b0;
		@(posedge clk);
		send_item(i5s_pkg::OP_SMOOTH, 16'd0, 32'd0);
		for (int i = 0; i < 20; i++)
			read_point($urandom_range(0, 767));
		drain();
	endtask

	// The receiver holds off while reads keep coming, filling the block.
	task automatic test_backpressure();
		configure(9'd4, 9'd4, 6'd2, 16'd40000, 16'd6000, 24'h018000);
		fill_grid();
		send_item(i5s_pkg::OP_SMOOTH, 16'd0, 32'd0);
		drain();
		stall_asked++;
		sender_gaps = 1'b0;
		for (int i = 0; i < 60; i++)
			read_point($urandom_range(0, 20));
		drain();
	endtask

	task automatic test_random_phases();
		int base;
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			sender_gaps = $urandom_range(0, 2) != 0;
			receiver_stalls = $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 9) == 0)
				configure(9'($urandom_range(257, 511)), 9'($urandom_range(0, 3)),
					6'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 24'($urandom));
			else
				configure(9'($urandom_range(0, 8)), 9'($urandom_range(0, 8)),
					$urandom_range(0, 7) == 0 ? 6'($urandom) : 6'($urandom_range(0, 4)),
					$urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom),
					$urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 20000)),
					$urandom_range(0, 4) == 0 ? 24'hFFFFFF : 24'($urandom_range(0, 24'h03FFFF)));
			fill_grid();
			for (int i = 0; i < $urandom_range(0, 4); i++)
				send_item(i5s_pkg::OP_WRITE, 16'($urandom), pick_sample());
			send_item(i5s_pkg::OP_SMOOTH, 16'($urandom), $urandom);
			for (int i = 0; i < $urandom_range(5, 30); i++)
				case ($urandom_range(0, 9))
					0: send_item(i5s_pkg::OP_NOP, 16'($urandom), $urandom);
					1: read_point($urandom_range(grid_points(), 65535));
					2: send_item(i5s_pkg::OP_WRITE,
						16'($urandom_range(0, grid_points() - 1)), pick_sample());
					3: send_item(i5s_pkg::OP_SMOOTH, 16'($urandom), $urandom);
					default: read_point($urandom_range(0, grid_points() - 1));
				endcase
			drain();
		end
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
	endtask

	// Receiver: long hold-off on request, otherwise its own stall pattern.
	always @(posedge clk) begin
		if (stall_served != stall_asked) begin
			stall_served = stall_asked;
			stall_left = 400;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (receiver_stalls) begin
			m_axis_tready <= $urandom_range(0, 3) != 0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report("unexpected beat", m_axis_tdata, 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata !== want.value)
					report("result_value", m_axis_tdata, want.value);
				if (m_axis_tuser !== want.done)
					report("result_valid", 32'(m_axis_tuser), 32'(want.done));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
				$display("FAIL iterated_five_point_smoother");
				$finish;
			end
		end
	end

	initial begin
		grid_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_clamp_zero_passes();
		test_wide_grid_max_passes();
		test_backpressure();
		test_random_phases();
		drain();
		repeat (20) @(posedge clk);
		while (pending_results.size() != 0) begin
			void'(pending_results.pop_front());
			report("missing beat", 32'd0, 32'd0);
		end
		$display("Covered %0d items: %0d smooth commands and %0d reads over clamped,",
			items_sent, smooths_run, reads_run);
		$display("wide and random grids with stalls and bursts; %0d mismatches.", mismatches);
		if (mismatches == 0)
			$display("PASS iterated_five_point_smoother");
		else
			$display("FAIL iterated_five_point_smoother");
		$finish;
	end

endmodule
